[rtl/twwb_pkg.sv]
`default_nettype none
package twwb_pkg;

  localparam int ADDR_W = 32;
  localparam int BUS_W  = 32;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [2:0] ACT_READ_DATA  = 3'd0;
  localparam logic [2:0] ACT_WRITE_DONE = 3'd1;
  localparam logic [2:0] ACT_FETCH      = 3'd2;
  localparam logic [2:0] ACT_WRITEBACK  = 3'd3;
  localparam logic [2:0] ACT_BUSY       = 3'd4;
  localparam logic [2:0] ACT_STRAY      = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [2:0]        action;
    logic [ADDR_W-1:0] address;
    logic [BUS_W-1:0]  data;
    logic              hit;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

[rtl/two_way_writeback_cache_core.sv]
// Two-way set-associative write-back cache, one word per line.
// Input channel: in_valid / in_stall carries kind (read, write, fill),
// word address and data. Result channel: out_valid / out_stall carries
// action, address, data, hit flag and a last flag that closes the results
// of one input item (a dirty victim write-back comes first, last low).
// Results of an item enter the result queue when it is processed and
// appear at the outputs from the following cycle. Throughput: one item
// per cycle while in_stall is low; the set memory, with one read and one
// write port, is read at accept, rewritten when the item is processed,
// with the written row forwarded to a back-to-back item on the same set.
// A four-entry result queue sits between the sides: while out_stall holds
// results back, items are still taken until fewer than two queue slots
// are free, then in_stall rises.
// Reset: a clearing pass writes all 2**INDEX_BITS sets back to zero tags
// and data, both lines dirty and way 1 next to replace; in_stall stays
// high throughout.
`default_nettype none
module two_way_writeback_cache_core #(
  parameter int INDEX_BITS = 8,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [twwb_pkg::ADDR_W-1:0] in_address,
  input  wire logic [twwb_pkg::BUS_W-1:0]  in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       out_action,
  output logic [twwb_pkg::ADDR_W-1:0]      out_address,
  output logic [twwb_pkg::BUS_W-1:0]       out_data,
  output logic                             out_was_hit,
  output logic                             out_last
);
  import twwb_pkg::*;

  localparam int SET_COUNT = 1 << INDEX_BITS;
  localparam int TAG_W     = ADDR_W - INDEX_BITS;
  localparam int DATA_W    = (WORD_WIDTH < BUS_W) ? WORD_WIDTH : BUS_W;

  typedef struct packed {
    logic [1:0][TAG_W-1:0]  tag;
    logic [1:0][DATA_W-1:0] data;
    logic [1:0]             dirty;
    logic                   mark;
  } row_t;

  row_t                  mem [SET_COUNT];
  row_t                  mem_q;
  row_t                  fwd_row_r;
  logic                  fwd_r;
  row_t                  row;

  logic                  clearing_r;
  logic [INDEX_BITS-1:0] clr_cnt_r;

  logic                  v_r;
  logic [1:0]            kind_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [DATA_W-1:0]     data_r;

  logic                  miss_pending_r, pend_nxt;
  logic [ADDR_W-1:0]     pending_addr_r, paddr_nxt;

  result_t               q_r [QDEPTH];
  logic [QPTR_W-1:0]     wp_r, rp_r;
  logic [QCNT_W-1:0]     cnt_r;

  logic                  go, accept, pop;
  logic [INDEX_BITS-1:0] rd_set, wr_set, cur_set;
  logic [TAG_W-1:0]      cur_tag;
  logic [ADDR_W-1:0]     cur_addr;
  logic                  wr_en;
  row_t                  wr_row, clr_row;
  logic                  hit0, hit1, hit, hway, vway, vdirty;
  result_t               res0, res1, wb, fin;
  logic [1:0]            n;

  assign go       = v_r && (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_stall = clearing_r || (v_r && !go);
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  assign row      = fwd_r ? fwd_row_r : mem_q;
  assign cur_addr = (kind_r == KIND_FILL) ? pending_addr_r : addr_r;
  assign cur_set  = cur_addr[INDEX_BITS-1:0];
  assign cur_tag  = cur_addr[ADDR_W-1:INDEX_BITS];
  assign hit0     = row.tag[0] == cur_tag;
  assign hit1     = row.tag[1] == cur_tag;
  assign hit      = hit0 || hit1;
  assign hway     = !hit0;
  assign vway     = row.mark;
  assign vdirty   = row.dirty[vway];

  always_comb begin
    clr_row       = '0;
    clr_row.dirty = 2'b11;
    clr_row.mark  = 1'b1;
  end

  always_comb begin
    wb         = '0;
    wb.action  = ACT_WRITEBACK;
    wb.address = {row.tag[vway], cur_set};
    wb.data    = BUS_W'(row.data[vway]);
    wr_en      = 1'b0;
    wr_set     = cur_set;
    wr_row     = row;
    n          = 2'd0;
    res0       = '0;
    res1       = '0;
    fin        = '0;
    fin.last   = 1'b1;
    pend_nxt   = miss_pending_r;
    paddr_nxt  = pending_addr_r;
    if (clearing_r) begin
      wr_en  = 1'b1;
      wr_set = clr_cnt_r;
      wr_row = clr_row;
    end else if (go) begin
      unique case (kind_r)
        KIND_FILL: begin
          if (!miss_pending_r) begin
            fin.action  = ACT_STRAY;
            fin.address = addr_r;
            res0        = fin;
            n           = 2'd1;
          end else begin
            fin.action           = ACT_READ_DATA;
            fin.address          = pending_addr_r;
            fin.data             = BUS_W'(data_r);
            wr_en                = 1'b1;
            wr_row.tag[vway]     = cur_tag;
            wr_row.data[vway]    = data_r;
            wr_row.dirty[vway]   = 1'b0;
            wr_row.mark          = !vway;
            pend_nxt             = 1'b0;
            res0                 = vdirty ? wb : fin;
            res1                 = fin;
            n                    = vdirty ? 2'd2 : 2'd1;
          end
        end
        KIND_READ, KIND_WRITE: begin
          fin.address = addr_r;
          if (miss_pending_r) begin
            fin.action = ACT_BUSY;
            res0       = fin;
            n          = 2'd1;
          end else if (hit) begin
            fin.hit     = 1'b1;
            wr_en       = 1'b1;
            wr_row.mark = !hway;
            if (kind_r == KIND_READ) begin
              fin.action = ACT_READ_DATA;
              fin.data   = BUS_W'(row.data[hway]);
            end else begin
              fin.action         = ACT_WRITE_DONE;
              wr_row.data[hway]  = data_r;
              wr_row.dirty[hway] = 1'b1;
            end
            res0 = fin;
            n    = 2'd1;
          end else if (kind_r == KIND_READ) begin
            fin.action = ACT_FETCH;
            pend_nxt   = 1'b1;
            paddr_nxt  = addr_r;
            res0       = fin;
            n          = 2'd1;
          end else begin
            fin.action         = ACT_WRITE_DONE;
            wr_en              = 1'b1;
            wr_row.tag[vway]   = cur_tag;
            wr_row.data[vway]  = data_r;
            wr_row.dirty[vway] = 1'b1;
            wr_row.mark        = !vway;
            res0               = vdirty ? wb : fin;
            res1               = fin;
            n                  = vdirty ? 2'd2 : 2'd1;
          end
        end
        default: begin
          n = 2'd0;
        end
      endcase
    end
  end

  assign rd_set = (in_kind == KIND_FILL) ? paddr_nxt[INDEX_BITS-1:0]
                                         : in_address[INDEX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (accept) begin
      mem_q <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r     <= wr_en && (wr_set == rd_set);
      fwd_row_r <= wr_row;
      kind_r    <= in_kind;
      addr_r    <= in_address;
      data_r    <= in_data[DATA_W-1:0];
    end
    if (n != 2'd0) begin
      q_r[wp_r] <= res0;
    end
    if (n == 2'd2) begin
      q_r[wp_r + QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r     <= 1'b1;
      clr_cnt_r      <= '0;
      v_r            <= 1'b0;
      miss_pending_r <= 1'b0;
      pending_addr_r <= '0;
      wp_r           <= '0;
      rp_r           <= '0;
      cnt_r          <= '0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + INDEX_BITS'(1);
        if (&clr_cnt_r) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        v_r <= 1'b1;
      end else if (go) begin
        v_r <= 1'b0;
      end
      miss_pending_r <= pend_nxt;
      pending_addr_r <= paddr_nxt;
      wp_r           <= wp_r + QPTR_W'(n);
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(n) - QCNT_W'(pop);
    end
  end

  assign out_valid   = cnt_r != '0;
  assign out_action  = q_r[rp_r].action;
  assign out_address = q_r[rp_r].address;
  assign out_data    = q_r[rp_r].data;
  assign out_was_hit = q_r[rp_r].hit;
  assign out_last    = q_r[rp_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> in_stall)
    else $error("item taken during clearing pass");

  a_miss_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (go && kind_r == KIND_READ && !miss_pending_r && !hit) |=> miss_pending_r)
    else $error("read miss left no pending fetch");

  a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !out_last) |=> out_valid)
    else $error("write-back result without its closing result");

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import twwb_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        drain;
  } cache_req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_NONE;
  logic [31:0] in_address = '0;
  logic [31:0] in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic [31:0] out_address;
  logic [31:0] out_data;
  logic        out_was_hit;
  logic        out_last;

  two_way_writeback_cache_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_address(in_address), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_action(out_action), .out_address(out_address), .out_data(out_data),
    .out_was_hit(out_was_hit), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  cache_req_t  pend_reqs[$];
  result_t     exp_results[$];
  int unsigned errors = 0;
  int unsigned acc_cnt = 0;

  // shadow cache state
  logic [23:0] tag_mem   [0:511];
  logic [31:0] data_mem  [0:511];
  logic        dirty_mem [0:511];
  logic        next_way  [0:255];
  logic        miss_open = 1'b0;
  logic [31:0] miss_addr = '0;

  initial begin
    for (int i = 0; i < 512; i++) begin
      tag_mem[i] = '0;
      data_mem[i] = '0;
      dirty_mem[i] = 1'b1;
    end
    for (int i = 0; i < 256; i++) next_way[i] = 1'b1;
  end

  function automatic void push_res(logic [2:0] act, logic [31:0] a, logic [31:0] d,
                                   logic h, logic l);
    result_t r;
    r.action = act;
    r.address = a;
    r.data = d;
    r.hit = h;
    r.last = l;
    exp_results.push_back(r);
  endfunction

  function automatic int unsigned evict_victim(logic [7:0] s);
    int unsigned slot;
    slot = s * 2 + next_way[s];
    if (dirty_mem[slot]) begin
      push_res(ACT_WRITEBACK, {tag_mem[slot], s}, data_mem[slot], 1'b0, 1'b0);
      dirty_mem[slot] = 1'b0;
    end
    return slot;
  endfunction

  function automatic void cache_predict(logic [1:0] kind, logic [31:0] addr, logic [31:0] d);
    logic [7:0]  s;
    logic [23:0] t;
    int unsigned slot;
    logic        hit;
    if (kind == KIND_NONE) return;
    if (kind == KIND_FILL) begin
      if (!miss_open) begin
        push_res(ACT_STRAY, addr, '0, 1'b0, 1'b1);
        return;
      end
      s = miss_addr[7:0];
      slot = evict_victim(s);
      tag_mem[slot] = miss_addr[31:8];
      data_mem[slot] = d;
      dirty_mem[slot] = 1'b0;
      next_way[s] = ~slot[0];
      miss_open = 1'b0;
      push_res(ACT_READ_DATA, miss_addr, d, 1'b0, 1'b1);
      return;
    end
    if (miss_open) begin
      push_res(ACT_BUSY, addr, '0, 1'b0, 1'b1);
      return;
    end
    s = addr[7:0];
    t = addr[31:8];
    hit = 1'b1;
    if (tag_mem[s * 2] == t) slot = s * 2;
    else if (tag_mem[s * 2 + 1] == t) slot = s * 2 + 1;
    else hit = 1'b0;
    if (kind == KIND_READ) begin
      if (hit) begin
        next_way[s] = ~slot[0];
        push_res(ACT_READ_DATA, addr, data_mem[slot], 1'b1, 1'b1);
      end else begin
        miss_open = 1'b1;
        miss_addr = addr;
        push_res(ACT_FETCH, addr, '0, 1'b0, 1'b1);
      end
      return;
    end
    if (!hit) slot = evict_victim(s);
    tag_mem[slot] = t;
    data_mem[slot] = d;
    dirty_mem[slot] = 1'b1;
    next_way[s] = ~slot[0];
    push_res(ACT_WRITE_DONE, addr, '0, hit, 1'b1);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // accept items and check results
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        cache_predict(in_kind, in_address, in_data);
        acc_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (exp_results.size() == 0) begin
          report("unexpected item, action", {29'd0, out_action}, '0);
        end else begin
          e = exp_results.pop_front();
          if (out_action !== e.action) report("action", {29'd0, out_action}, {29'd0, e.action});
          if (out_address !== e.address) report("address", out_address, e.address);
          if (out_data !== e.data) report("data", out_data, e.data);
          if (out_was_hit !== e.hit) report("was_hit", {31'd0, out_was_hit}, {31'd0, e.hit});
          if (out_last !== e.last) report("last", {31'd0, out_last}, {31'd0, e.last});
        end
      end
    end
  end

  // sender: bursts and gaps
  int unsigned seen_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always @(negedge clk) begin
    cache_req_t nxt;
    logic       v;
    if (rst_n) begin
      v = in_valid;
      if (in_valid && acc_cnt != seen_cnt) begin
        seen_cnt = acc_cnt;
        v = 1'b0;
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_reqs.size() > 0 &&
                     !(pend_reqs[0].drain && exp_results.size() > 0)) begin
          nxt = pend_reqs.pop_front();
          v = 1'b1;
          in_kind <= nxt.kind;
          in_address <= nxt.addr;
          in_data <= nxt.data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= v;
    end
  end

  // receiver: stall pattern with occasional long hold-off
  int unsigned rx_cyc = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;

  always @(negedge clk) begin
    logic s;
    rx_cyc++;
    if (rx_cyc % 400 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      s = 1'b1;
    end else if (rx_cyc % 2000 == 1000) begin
      hold_left = 300;
      s = 1'b1;
    end else begin
      case (rx_mode)
        0: s = 1'b0;
        1: s = ($urandom_range(0, 3) == 0);
        2: s = ($urandom_range(0, 4) != 0);
        default: s = rx_cyc[2];
      endcase
    end
    out_stall <= s;
  end

  function automatic void add_req(logic [1:0] k, logic [31:0] a, logic [31:0] d, logic dr);
    cache_req_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    r.drain = dr;
    pend_reqs.push_back(r);
  endfunction

  function automatic logic [31:0] rand_addr();
    int unsigned r;
    logic [23:0] t;
    logic [7:0]  s;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    t = 24'($urandom_range(0, 5));
    if (t == 24'd5) t = 24'hFFFFFF;
    if (r < 25) s = 8'hFF;
    else s = 8'($urandom_range(0, 3));
    return {t, s};
  endfunction

  function automatic logic [31:0] rand_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h0;
    if (r < 10) return 32'hFFFFFFFF;
    return $urandom;
  endfunction

  initial begin
    int unsigned n;
    int unsigned r;
    logic        drained;
    add_req(KIND_READ,  32'h00000000, 32'h0, 1'b0);
    add_req(KIND_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    add_req(KIND_READ,  32'hFFFFFFFF, 32'h0, 1'b0);
    add_req(KIND_READ,  32'h12345600, 32'h0, 1'b0);
    add_req(KIND_WRITE, 32'h00000001, 32'h5, 1'b0);
    add_req(KIND_READ,  32'h00000002, 32'h0, 1'b0);
    add_req(KIND_NONE,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    add_req(KIND_FILL,  32'hAAAAAAAA, 32'hFFFFFFFF, 1'b0);
    add_req(KIND_FILL,  32'h55555555, 32'h12345678, 1'b0);
    add_req(KIND_READ,  32'h12345600, 32'h0, 1'b0);
    add_req(KIND_WRITE, 32'h00000000, 32'h0, 1'b0);
    add_req(KIND_WRITE, 32'h55555500, 32'h55555555, 1'b0);
    add_req(KIND_READ,  32'h55555500, 32'h0, 1'b0);
    add_req(KIND_READ,  32'h77777700, 32'h0, 1'b0);
    add_req(KIND_FILL,  32'h0, 32'h0, 1'b0);
    add_req(KIND_NONE,  32'h0, 32'h0, 1'b0);
    add_req(KIND_WRITE, 32'h0000007F, 32'h80000000, 1'b0);
    add_req(KIND_READ,  32'hFFFFFF00, 32'h0, 1'b0);
    add_req(KIND_FILL,  32'hFFFFFFFF, 32'hAAAAAAAA, 1'b0);
    add_req(KIND_READ,  32'h0000007F, 32'h0, 1'b0);

    n = 0;
    drained = 1'b0;
    while (n < 2000) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        add_req(KIND_READ, rand_addr(), rand_data(), !drained && n >= 1000);
        if (n >= 1000) drained = 1'b1;
        n++;
        if ($urandom_range(0, 3) != 0) begin
          add_req(KIND_FILL, rand_addr(), rand_data(), 1'b0);
          n++;
        end
      end else if (r < 78) begin
        add_req(KIND_WRITE, rand_addr(), rand_data(), 1'b0);
        n++;
      end else if (r < 86) begin
        add_req(KIND_FILL, rand_addr(), rand_data(), 1'b0);
        n++;
      end else if (r < 92) begin
        add_req(KIND_NONE, $urandom, $urandom, 1'b0);
      end else begin
        add_req(KIND_READ, $urandom, $urandom, 1'b0);
        n++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pend_reqs.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (exp_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && exp_results.size() == 0) begin
      $display("PASS two_way_writeback_cache_core");
    end else begin
      $display("FAIL two_way_writeback_cache_core");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL two_way_writeback_cache_core");
    $finish;
  end

endmodule
`default_nettype wire
